[rtl/cfd_pkg.sv]
`timescale 1ns / 1ps

package cfd_pkg;

   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   localparam logic [15:0] MAX_LENGTH_RESET = 16'd1013;

   // configuration register indexes
   localparam logic [1:0] CSR_HEAD_BYTE       = 2'd0;
   localparam logic [1:0] CSR_TAIL_BYTE       = 2'd1;
   localparam logic [1:0] CSR_MAX_DATA_LENGTH = 2'd2;

   typedef enum logic [2:0] {
      KIND_PAYLOAD = 3'd0,
      KIND_GOOD    = 3'd1,
      KIND_BADSUM  = 3'd2,
      KIND_BADTAIL = 3'd3,
      KIND_TOOLONG = 3'd4,
      KIND_NOFRAME = 3'd5
   } kind_type;

   // one classified byte: up to one frame result plus an optional no-frame result
   typedef struct packed {
      logic        has_status;
      logic        has_noframe;
      kind_type    kind;
      logic [7:0]  payload_byte;
      logic [31:0] device_id;
      logic [7:0]  command;
      logic [7:0]  joint_id;
      logic [15:0] data_length;
      logic [7:0]  received_sum;
   } entry_type;

   typedef struct packed {
      logic [7:0]  head_byte;
      logic [7:0]  tail_byte;
      logic [15:0] max_data_length;
   } csr_type;

endpackage

[rtl/cfd_front.sv]
`timescale 1ns / 1ps

module cfd_front import cfd_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  csr_type    csr,
   input  logic       accept,
   input  logic [7:0] in_byte,
   input  logic       end_of_buffer,
   output logic       entry_push,
   output entry_type  entry
);

   typedef enum logic [3:0] {
      PH_HUNT    = 4'd0,
      PH_ID0     = 4'd1,
      PH_ID1     = 4'd2,
      PH_ID2     = 4'd3,
      PH_ID3     = 4'd4,
      PH_CMD     = 4'd5,
      PH_JOINT   = 4'd6,
      PH_LEN0    = 4'd7,
      PH_LEN1    = 4'd8,
      PH_PAYLOAD = 4'd9,
      PH_SUM     = 4'd10,
      PH_TAIL    = 4'd11,
      PH_DONE    = 4'd12
   } phase_type;

   phase_type   phase_ff, phase_in;
   logic [15:0] count_ff, count_in;
   logic [31:0] id_ff, id_in;
   logic [7:0]  cmd_ff, cmd_in;
   logic [7:0]  joint_ff, joint_in;
   logic [15:0] length_ff, length_in;
   logic [7:0]  rsum_ff, rsum_in;
   logic [7:0]  sumbyte_ff, sumbyte_in;
   logic        found_ff, found_in;
   logic        has_status;
   kind_type    kind;
   logic [15:0] count_inc;

   assign count_inc = count_ff + 16'd1;

   always_comb begin
      phase_in   = phase_ff;
      count_in   = count_ff;
      id_in      = id_ff;
      cmd_in     = cmd_ff;
      joint_in   = joint_ff;
      length_in  = length_ff;
      rsum_in    = rsum_ff;
      sumbyte_in = sumbyte_ff;
      found_in   = found_ff;
      has_status = 1'b0;
      kind       = KIND_PAYLOAD;

      case (phase_ff)
         PH_HUNT: begin
            if (in_byte == csr.head_byte) begin
               id_in      = '0;
               rsum_in    = '0;
               count_in   = '0;
               length_in  = '0;
               cmd_in     = '0;
               joint_in   = '0;
               sumbyte_in = '0;
               phase_in   = PH_ID0;
            end
         end
         PH_ID0: begin
            id_in[7:0] = in_byte;
            rsum_in    = rsum_ff + in_byte;
            phase_in   = PH_ID1;
         end
         PH_ID1: begin
            id_in[15:8] = in_byte;
            rsum_in     = rsum_ff + in_byte;
            phase_in    = PH_ID2;
         end
         PH_ID2: begin
            id_in[23:16] = in_byte;
            rsum_in      = rsum_ff + in_byte;
            phase_in     = PH_ID3;
         end
         PH_ID3: begin
            id_in[31:24] = in_byte;
            rsum_in      = rsum_ff + in_byte;
            phase_in     = PH_CMD;
         end
         PH_CMD: begin
            cmd_in   = in_byte;
            rsum_in  = rsum_ff + in_byte;
            phase_in = PH_JOINT;
         end
         PH_JOINT: begin
            joint_in = in_byte;
            rsum_in  = rsum_ff + in_byte;
            phase_in = PH_LEN0;
         end
         PH_LEN0: begin
            length_in = {8'h00, in_byte};
            rsum_in   = rsum_ff + in_byte;
            phase_in  = PH_LEN1;
         end
         PH_LEN1: begin
            length_in = {in_byte, length_ff[7:0]};
            rsum_in   = rsum_ff + in_byte;
            count_in  = '0;
            if (length_in > csr.max_data_length) begin
               has_status = 1'b1;
               kind       = KIND_TOOLONG;
               phase_in   = PH_HUNT;
            end else if (length_in != 16'd0) begin
               phase_in = PH_PAYLOAD;
            end else begin
               phase_in = PH_SUM;
            end
         end
         PH_PAYLOAD: begin
            rsum_in    = rsum_ff + in_byte;
            has_status = 1'b1;
            kind       = KIND_PAYLOAD;
            count_in   = count_inc;
            if (count_inc >= length_ff) phase_in = PH_SUM;
         end
         PH_SUM: begin
            sumbyte_in = in_byte;
            phase_in   = PH_TAIL;
         end
         PH_TAIL: begin
            has_status = 1'b1;
            if (in_byte != csr.tail_byte) begin
               kind     = KIND_BADTAIL;
               phase_in = PH_HUNT;
            end else if (sumbyte_ff != rsum_ff) begin
               kind     = KIND_BADSUM;
               phase_in = PH_HUNT;
            end else begin
               kind     = KIND_GOOD;
               found_in = 1'b1;
               phase_in = PH_DONE;
            end
         end
         PH_DONE: begin
         end
         default: phase_in = PH_HUNT;
      endcase

      // header snapshot taken after this byte's update, before the buffer-end clear
      entry.has_status   = has_status;
      entry.has_noframe  = end_of_buffer && !found_in;
      entry.kind         = kind;
      entry.payload_byte = (kind == KIND_PAYLOAD) ? in_byte : 8'h00;
      entry.device_id    = id_in;
      entry.command      = cmd_in;
      entry.joint_id     = joint_in;
      entry.data_length  = length_in;
      entry.received_sum = (kind inside {KIND_GOOD, KIND_BADSUM, KIND_BADTAIL})
                           ? sumbyte_ff : 8'h00;

      if (end_of_buffer) begin
         phase_in   = PH_HUNT;
         count_in   = '0;
         id_in      = '0;
         cmd_in     = '0;
         joint_in   = '0;
         length_in  = '0;
         rsum_in    = '0;
         sumbyte_in = '0;
         found_in   = 1'b0;
      end
   end

   assign entry_push = accept && (entry.has_status || entry.has_noframe);

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_HUNT;
         count_ff   <= '0;
         id_ff      <= '0;
         cmd_ff     <= '0;
         joint_ff   <= '0;
         length_ff  <= '0;
         rsum_ff    <= '0;
         sumbyte_ff <= '0;
         found_ff   <= 1'b0;
      end else if (accept) begin
         phase_ff   <= phase_in;
         count_ff   <= count_in;
         id_ff      <= id_in;
         cmd_ff     <= cmd_in;
         joint_ff   <= joint_in;
         length_ff  <= length_in;
         rsum_ff    <= rsum_in;
         sumbyte_ff <= sumbyte_in;
         found_ff   <= found_in;
      end
   end

   a_eob_clears: assert property (@(posedge clock) disable iff (reset)
      accept && end_of_buffer |=> phase_ff == PH_HUNT && !found_ff)
      else $error("buffer end did not return the parser to hunting");

   a_found_only_done: assert property (@(posedge clock) disable iff (reset)
      found_ff |-> phase_ff == PH_DONE)
      else $error("good frame flag set outside the done phase");

endmodule

[rtl/cfd_queue.sv]
`timescale 1ns / 1ps

module cfd_queue import cfd_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      push,
   input  entry_type push_data,
   input  logic      pop,
   output entry_type head_data,
   output logic      empty,
   output logic      full
);

   entry_type                slot_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [QUEUE_CNT_W-1:0]   count_ff;
   logic                     do_push, do_pop;

   assign empty     = (count_ff == '0);
   assign full      = (count_ff == QUEUE_CNT_W'(QUEUE_DEPTH));
   assign do_push   = push && !full;
   assign do_pop    = pop && !empty;
   assign head_data = slot_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (do_push) slot_ff[wr_ptr_ff] <= push_data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) wr_ptr_ff <= (wr_ptr_ff == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                   : wr_ptr_ff + 1'b1;
         if (do_pop) rd_ptr_ff <= (rd_ptr_ff == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                  : rd_ptr_ff + 1'b1;
         if (do_push && !do_pop) count_ff <= count_ff + 1'b1;
         else if (do_pop && !do_push) count_ff <= count_ff - 1'b1;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= QUEUE_CNT_W'(QUEUE_DEPTH))
      else $error("queue count above depth");

   a_no_lost_push: assert property (@(posedge clock) disable iff (reset)
      push |-> !full)
      else $error("entry pushed into a full queue");

endmodule

[rtl/cfd_back.sv]
`timescale 1ns / 1ps

module cfd_back import cfd_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  entry_type   head_data,
   input  logic        head_empty,
   output logic        head_pop,
   input  logic        rsp_pop,
   output logic        rsp_empty,
   output logic [2:0]  rsp_kind,
   output logic [7:0]  rsp_payload_byte,
   output logic [31:0] rsp_device_id,
   output logic [7:0]  rsp_command,
   output logic [7:0]  rsp_joint_id,
   output logic [15:0] rsp_data_length,
   output logic [7:0]  rsp_received_sum,
   output logic        rsp_last_of_run
);

   logic        valid_ff;
   logic        second_ff;   // working on the no-frame beat of a two-result entry
   logic        load;
   logic        two_results;
   logic        emit_noframe;
   logic        cur_last;
   kind_type    kind_ff;
   logic [7:0]  payload_ff;
   logic [31:0] id_ff;
   logic [7:0]  cmd_ff;
   logic [7:0]  joint_ff;
   logic [15:0] length_ff;
   logic [7:0]  rsum_ff;
   logic        last_ff;

   assign two_results  = head_data.has_status && head_data.has_noframe;
   assign emit_noframe = second_ff || !head_data.has_status;
   assign cur_last     = second_ff || !two_results;
   assign load         = !head_empty && (!valid_ff || rsp_pop);
   assign head_pop     = load && cur_last;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff  <= 1'b0;
         second_ff <= 1'b0;
      end else begin
         if (load) valid_ff <= 1'b1;
         else if (rsp_pop) valid_ff <= 1'b0;
         if (load) second_ff <= !cur_last;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         if (emit_noframe) begin
            kind_ff    <= KIND_NOFRAME;
            payload_ff <= '0;
            id_ff      <= '0;
            cmd_ff     <= '0;
            joint_ff   <= '0;
            length_ff  <= '0;
            rsum_ff    <= '0;
         end else begin
            kind_ff    <= head_data.kind;
            payload_ff <= head_data.payload_byte;
            id_ff      <= head_data.device_id;
            cmd_ff     <= head_data.command;
            joint_ff   <= head_data.joint_id;
            length_ff  <= head_data.data_length;
            rsum_ff    <= head_data.received_sum;
         end
         last_ff <= cur_last;
      end
   end

   assign rsp_empty        = !valid_ff;
   assign rsp_kind         = kind_ff;
   assign rsp_payload_byte = payload_ff;
   assign rsp_device_id    = id_ff;
   assign rsp_command      = cmd_ff;
   assign rsp_joint_id     = joint_ff;
   assign rsp_data_length  = length_ff;
   assign rsp_received_sum = rsum_ff;
   assign rsp_last_of_run  = last_ff;

   a_second_has_pair: assert property (@(posedge clock) disable iff (reset)
      second_ff |-> !head_empty && two_results)
      else $error("second beat pending without a two-result entry");

   a_second_after_first: assert property (@(posedge clock) disable iff (reset)
      $rose(second_ff) |-> valid_ff && !last_ff)
      else $error("no-frame beat queued without a leading status beat");

endmodule

[rtl/checksummed_frame_deframer.sv]
`timescale 1ns / 1ps
// an accepted byte's entry is registered in a queue slot, then in the result register
// throughput: one byte per cycle while the queue is not full; the result side moves
// one beat per cycle while beats are popped; a buffer-end byte with a status other than
// a good frame gives two beats from one entry; a 4-entry queue absorbs those bursts
// reset (synchronous): parser hunts for a head byte, queue and result empty, head and
// tail bytes 0, length limit 1013

module checksummed_frame_deframer import cfd_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   output logic        req_full,
   input  logic [7:0]  req_in_byte,
   input  logic        req_end_of_buffer,
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output logic [2:0]  rsp_kind,
   output logic [7:0]  rsp_payload_byte,
   output logic [31:0] rsp_device_id,
   output logic [7:0]  rsp_command,
   output logic [7:0]  rsp_joint_id,
   output logic [15:0] rsp_data_length,
   output logic [7:0]  rsp_received_sum,
   output logic        rsp_last_of_run,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_data
);

   csr_type   csr_ff;
   logic      accept;
   logic      entry_push;
   entry_type entry;
   entry_type head_data;
   logic      head_empty;
   logic      head_pop;

   assign csr_ready = 1'b1;
   assign accept    = req_push && !req_full;

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff.head_byte       <= '0;
         csr_ff.tail_byte       <= '0;
         csr_ff.max_data_length <= MAX_LENGTH_RESET;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_HEAD_BYTE:       csr_ff.head_byte       <= csr_data[7:0];
            CSR_TAIL_BYTE:       csr_ff.tail_byte       <= csr_data[7:0];
            CSR_MAX_DATA_LENGTH: csr_ff.max_data_length <= csr_data;
            default: ;
         endcase
      end
   end

   cfd_front u_front (
      .clock         (clock),
      .reset         (reset),
      .csr           (csr_ff),
      .accept        (accept),
      .in_byte       (req_in_byte),
      .end_of_buffer (req_end_of_buffer),
      .entry_push    (entry_push),
      .entry         (entry)
   );

   cfd_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (entry_push),
      .push_data (entry),
      .pop       (head_pop),
      .head_data (head_data),
      .empty     (head_empty),
      .full      (req_full)
   );

   cfd_back u_back (
      .clock            (clock),
      .reset            (reset),
      .head_data        (head_data),
      .head_empty       (head_empty),
      .head_pop         (head_pop),
      .rsp_pop          (rsp_pop),
      .rsp_empty        (rsp_empty),
      .rsp_kind         (rsp_kind),
      .rsp_payload_byte (rsp_payload_byte),
      .rsp_device_id    (rsp_device_id),
      .rsp_command      (rsp_command),
      .rsp_joint_id     (rsp_joint_id),
      .rsp_data_length  (rsp_data_length),
      .rsp_received_sum (rsp_received_sum),
      .rsp_last_of_run  (rsp_last_of_run)
   );

endmodule
